// ===== rtl/core/lssr_pkg.sv =====
// ----------------------------------------------------------------------------
// lssr_pkg
// Shared types and constants for the line scan sensor readout unit.
// ----------------------------------------------------------------------------
package lssr_pkg;

  localparam int unsigned PIXELS_DEF      = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned THR_W   = 12;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 1;

  localparam logic [UNIT_W-1:0] DELAY_UNIT_RST = 16'd1000;
  localparam logic [THR_W-1:0]  DARK_THR_RST   = 12'd200;

  localparam logic [CIDX_W-1:0] REG_DELAY_UNIT = 1'b0;
  localparam logic [CIDX_W-1:0] REG_DARK_THR   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE_A = 3'd1,
    PH_PRE_B = 3'd2,
    PH_PRE_C = 3'd3,
    PH_PIX_A = 3'd4,
    PH_PIX_B = 3'd5,
    PH_TRL_A = 3'd6,
    PH_TRL_B = 3'd7
  } phase_t;

  typedef struct packed {
    logic [UNIT_W-1:0] delay_unit;
    logic [THR_W-1:0]  dark_threshold;
  } cfg_t;

  typedef struct packed {
    logic             clk_level;
    logic             si_level;
    logic             pixel_valid;
    logic [IDX_W-1:0] pixel_index;
    logic             pixel_bit;
    logic             busy_res;
    logic             frame_done;
  } res_t;

endpackage

// ===== rtl/core/lssr_seq.sv =====
// ----------------------------------------------------------------------------
// lssr_seq
// Frame sequencer: SI/CLK timing, wait unit counting and pixel threshold.
// State advances once per accepted tick; the result is combinational.
// ----------------------------------------------------------------------------
module lssr_seq
  import lssr_pkg::*;
#(
  parameter int unsigned PIXELS      = PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             kind,
  input  logic [ADC_W-1:0] adc_sample,
  input  cfg_t             cfg,
  output res_t             res
);

  localparam int unsigned PCW = $clog2(PIXELS + 1);
  localparam logic [PCW:0] PIX_LIM = (PCW + 1)'(PIXELS);
  localparam logic [ADC_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << SAMPLE_BITS) - 1);

  phase_t            phase_r, phase_nxt;
  logic [UNIT_W-1:0] tick_r, tick_nxt;
  logic [1:0]        units_r, units_nxt;
  logic [PCW-1:0]    pcnt_r, pcnt_nxt;
  logic              clk_r, clk_nxt;
  logic              si_r, si_nxt;

  logic [UNIT_W-1:0] unit;
  logic [UNIT_W:0]   tick_inc;
  logic              expire;
  logic [1:0]        units_dec;
  logic [PCW:0]      pcnt_inc;
  logic [ADC_W-1:0]  sample_m;
  logic              pix_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      units_r <= '0;
      pcnt_r  <= '0;
      clk_r   <= 1'b0;
      si_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      units_r <= units_nxt;
      pcnt_r  <= pcnt_nxt;
      clk_r   <= clk_nxt;
      si_r    <= si_nxt;
    end
  end

  assign unit      = (cfg.delay_unit == '0) ? UNIT_W'(1) : cfg.delay_unit;
  assign tick_inc  = {1'b0, tick_r} + (UNIT_W + 1)'(1);
  assign expire    = (tick_inc >= {1'b0, unit});
  assign units_dec = (units_r != 2'd0) ? units_r - 2'd1 : 2'd0;
  assign pcnt_inc  = {1'b0, pcnt_r} + (PCW + 1)'(1);
  assign sample_m  = adc_sample & SAMPLE_MASK;
  assign pix_bit   = (sample_m > cfg.dark_threshold) ? 1'b0 : 1'b1;

  always_comb begin
    phase_nxt       = phase_r;
    tick_nxt        = tick_r;
    units_nxt       = units_r;
    pcnt_nxt        = pcnt_r;
    clk_nxt         = clk_r;
    si_nxt          = si_r;
    res.pixel_valid = 1'b0;
    res.pixel_index = '0;
    res.pixel_bit   = 1'b0;
    res.frame_done  = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (kind) begin
        si_nxt    = 1'b1;
        clk_nxt   = 1'b0;
        tick_nxt  = '0;
        units_nxt = 2'd2;
        pcnt_nxt  = '0;
        phase_nxt = PH_PRE_A;
      end
    end else begin
      tick_nxt = tick_inc[UNIT_W-1:0];
      if (expire) begin
        tick_nxt  = '0;
        units_nxt = units_dec;
        if (units_dec == 2'd0) begin
          case (phase_r)
            PH_PRE_A: begin
              clk_nxt   = 1'b1;
              phase_nxt = PH_PRE_B;
              units_nxt = 2'd1;
            end
            PH_PRE_B: begin
              si_nxt    = 1'b0;
              phase_nxt = PH_PRE_C;
              units_nxt = 2'd1;
            end
            PH_PRE_C: begin
              res.pixel_valid = 1'b1;
              res.pixel_bit   = pix_bit;
              clk_nxt         = 1'b0;
              pcnt_nxt        = PCW'(1);
              phase_nxt       = PH_PIX_A;
              units_nxt       = 2'd2;
            end
            PH_PIX_A: begin
              clk_nxt   = 1'b1;
              phase_nxt = PH_PIX_B;
              units_nxt = 2'd2;
            end
            PH_PIX_B: begin
              res.pixel_valid = 1'b1;
              res.pixel_index = IDX_W'(pcnt_r);
              res.pixel_bit   = pix_bit;
              clk_nxt         = 1'b0;
              pcnt_nxt        = pcnt_inc[PCW-1:0];
              phase_nxt       = (pcnt_inc >= PIX_LIM) ? PH_TRL_A : PH_PIX_A;
              units_nxt       = 2'd2;
            end
            PH_TRL_A: begin
              clk_nxt   = 1'b1;
              phase_nxt = PH_TRL_B;
              units_nxt = 2'd2;
            end
            default: begin
              clk_nxt        = 1'b0;
              si_nxt         = 1'b0;
              phase_nxt      = PH_IDLE;
              units_nxt      = 2'd0;
              pcnt_nxt       = '0;
              res.frame_done = 1'b1;
            end
          endcase
        end
      end
    end

    res.clk_level = clk_nxt;
    res.si_level  = si_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

endmodule

// ===== rtl/core/line_scan_sensor_readout_unit.sv =====
// ----------------------------------------------------------------------------
// line_scan_sensor_readout_unit
// Linear sensor SI/CLK readout with per-pixel threshold, stream interface.
// ----------------------------------------------------------------------------
// Results are registered; a two-entry output buffer keeps accepting one more
// request while a result waits. Throughput: 1 request per cycle while
// in_tready is high; in_tready is low while the second (skid) entry is full.
// Reset (rst_n low, synchronous): sequencer idle, lines low, buffer empty,
// delay_unit 1000 and dark_threshold 200.
module line_scan_sensor_readout_unit
  import lssr_pkg::*;
#(
  parameter int unsigned PIXELS      = PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [11:0] adc_sample, [15:12] zero
  input  logic              in_tuser,   // [0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [0] clk_level, [1] si_level,
                                        // [8:2] pixel_index, [9] pixel_bit,
                                        // [10] busy_res, [15:11] zero
  output logic              out_tuser,  // [0] pixel_valid
  output logic              out_tlast   // frame_done
);

  cfg_t cfg_r;
  res_t res;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic acc, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_unit     <= DELAY_UNIT_RST;
      cfg_r.dark_threshold <= DARK_THR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DELAY_UNIT: cfg_r.delay_unit     <= cfg_wdata;
        REG_DARK_THR:   cfg_r.dark_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign take      = out_valid_r && out_tready;

  lssr_seq #(
    .PIXELS      (PIXELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (acc),
    .kind       (in_tuser),
    .adc_sample (in_tdata[ADC_W-1:0]),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= acc;
        end
      end else if (acc) begin
        if (out_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      if (out_valid_r) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.busy_res, out_r.pixel_bit, out_r.pixel_index,
                       out_r.si_level, out_r.clk_level};
  assign out_tuser  = out_r.pixel_valid;
  assign out_tlast  = out_r.frame_done;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_done) |-> !out_r.busy_res && !out_r.pixel_valid)
    else $error("frame done result still busy or carrying a pixel");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.pixel_valid) |->
      (out_r.pixel_index == '0) && !out_r.pixel_bit)
    else $error("pixel fields nonzero without a pixel");

endmodule
